[rtl/core/modem_power_config_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modem power configuration sequencer
// Shared property wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODEM_POWER_CONFIG_SEQUENCER_CORE_DEFINES_SVH
`define MODEM_POWER_CONFIG_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define MPCS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mpcs_pkg.sv]
// ----------------------------------------------------------------------------
// mpcs_pkg
// Shared codes and types of the modem power configuration sequencer.
// ----------------------------------------------------------------------------
package mpcs_pkg;

  localparam logic [2:0] CmdTick    = 3'd0;
  localparam logic [2:0] CmdPinAck  = 3'd1;
  localparam logic [2:0] CmdAlive   = 3'd2;
  localparam logic [2:0] CmdCfgDone = 3'd3;
  localparam logic [2:0] CmdStart   = 3'd4;

  localparam logic [1:0] KindSetPin = 2'd0;
  localparam logic [1:0] KindCfgReq = 2'd1;
  localparam logic [1:0] KindStart  = 2'd2;
  localparam logic [1:0] KindEnd    = 2'd3;

  localparam logic [1:0] CfgModemPin  = 2'd0;
  localparam logic [1:0] CfgMagnetPin = 2'd1;
  localparam logic [1:0] CfgEnable    = 2'd2;

  // one queued tick: either the three-word start burst or a single word
  typedef struct packed {
    logic       multi;
    logic [1:0] kind;
    logic [3:0] pin;
    logic       level;
    logic [7:0] role;
  } burst_t;

  typedef struct packed {
    logic [3:0] modem_pin;
    logic [3:0] magnet_pin;
    logic       enabled;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/mpcs_front.sv]
// ----------------------------------------------------------------------------
// mpcs_front
// Accepts input words, walks the phase register and queues tick bursts.
// ----------------------------------------------------------------------------
module mpcs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          cmd_i,
  input  logic [3:0]          ack_pin_i,
  input  logic [3:0]          ack_level_i,
  input  logic [7:0]          role_code_i,
  input  mpcs_pkg::cfg_t      cfg_i,
  input  mpcs_pkg::q_stat_t   q_stat_i,
  output logic                push_o,
  output mpcs_pkg::burst_t    entry_o
);

  localparam logic [3:0] PhIdle      = 4'd0;
  localparam logic [3:0] PhBegin     = 4'd1;
  localparam logic [3:0] PhWaitOff1  = 4'd2;
  localparam logic [3:0] PhMagOn     = 4'd3;
  localparam logic [3:0] PhWaitMagOn = 4'd4;
  localparam logic [3:0] PhModemOn   = 4'd5;
  localparam logic [3:0] PhWaitOn1   = 4'd6;
  localparam logic [3:0] PhWaitAlive = 4'd7;
  localparam logic [3:0] PhMagOff    = 4'd8;
  localparam logic [3:0] PhWaitMagOf = 4'd9;
  localparam logic [3:0] PhWaitCfg   = 4'd10;
  localparam logic [3:0] PhModemOff  = 4'd11;
  localparam logic [3:0] PhWaitOff2  = 4'd12;
  localparam logic [3:0] PhModemOn2  = 4'd13;
  localparam logic [3:0] PhWaitOn2   = 4'd14;
  localparam logic [3:0] PhFinal     = 4'd15;

  logic [3:0] phase_q, phase_d;
  logic [7:0] role_q, role_d;
  logic       accept;
  logic       ack_ok;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign ack_ok     = (ack_level_i[3:1] == 3'd0) && !ack_pin_i[3];

  always_comb begin
    phase_d = phase_q;
    role_d  = role_q;
    push_o  = 1'b0;
    entry_o = '{multi: 1'b0, kind: mpcs_pkg::KindSetPin, pin: 4'd0, level: 1'b0,
                role: 8'd0};
    if (accept) begin
      case (cmd_i)
        mpcs_pkg::CmdTick: begin
          if (cfg_i.enabled) begin
            case (phase_q)
              PhBegin: begin
                push_o        = 1'b1;
                entry_o.multi = 1'b1;
                entry_o.pin   = cfg_i.modem_pin;
                entry_o.role  = role_q;
                phase_d       = PhWaitOff1;
              end
              PhMagOn: begin
                push_o        = 1'b1;
                entry_o.pin   = cfg_i.magnet_pin;
                entry_o.level = 1'b1;
                phase_d       = PhWaitMagOn;
              end
              PhModemOn: begin
                push_o        = 1'b1;
                entry_o.pin   = cfg_i.modem_pin;
                entry_o.level = 1'b1;
                phase_d       = PhWaitOn1;
              end
              PhMagOff: begin
                push_o      = 1'b1;
                entry_o.pin = cfg_i.magnet_pin;
                phase_d     = PhWaitMagOf;
              end
              PhModemOff: begin
                push_o      = 1'b1;
                entry_o.pin = cfg_i.modem_pin;
                phase_d     = PhWaitOff2;
              end
              PhModemOn2: begin
                push_o        = 1'b1;
                entry_o.pin   = cfg_i.modem_pin;
                entry_o.level = 1'b1;
                phase_d       = PhWaitOn2;
              end
              PhFinal: begin
                push_o       = 1'b1;
                entry_o.kind = mpcs_pkg::KindEnd;
                phase_d      = PhIdle;
              end
              default: ;
            endcase
          end
        end
        mpcs_pkg::CmdPinAck: begin
          if (ack_ok) begin
            if (ack_pin_i == cfg_i.modem_pin) begin
              case (phase_q)
                PhWaitOff1: phase_d = PhMagOn;
                PhWaitOn1:  phase_d = PhWaitAlive;
                PhWaitOff2: phase_d = PhModemOn2;
                PhWaitOn2:  phase_d = PhFinal;
                default: ;
              endcase
            end else if (ack_pin_i == cfg_i.magnet_pin) begin
              case (phase_q)
                PhWaitMagOn: phase_d = PhModemOn;
                PhWaitMagOf: phase_d = PhWaitCfg;
                default: ;
              endcase
            end
          end
        end
        mpcs_pkg::CmdAlive: begin
          if (phase_q == PhWaitAlive) phase_d = PhMagOff;
        end
        mpcs_pkg::CmdCfgDone: begin
          if (phase_q == PhWaitCfg) phase_d = PhModemOff;
        end
        mpcs_pkg::CmdStart: begin
          phase_d = PhBegin;
          role_d  = role_code_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      role_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      role_q  <= role_d;
    end
  end

endmodule

[rtl/core/mpcs_queue.sv]
// ----------------------------------------------------------------------------
// mpcs_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module mpcs_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mpcs_pkg::burst_t   wdata_i,
  input  logic               pop_i,
  output mpcs_pkg::burst_t   rdata_o,
  output mpcs_pkg::q_stat_t  stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mpcs_pkg::burst_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/core/mpcs_back.sv]
// ----------------------------------------------------------------------------
// mpcs_back
// Expands queued bursts into result words behind an output register.
// ----------------------------------------------------------------------------
module mpcs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpcs_pkg::burst_t   head_i,
  input  mpcs_pkg::q_stat_t  q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [3:0]         pin_o,
  output logic               level_o,
  output logic [7:0]         role_o,
  output logic               last_o
);

  localparam logic [1:0] BeatFirst = 2'd0;
  localparam logic [1:0] BeatCfg   = 2'd1;
  localparam logic [1:0] BeatPin   = 2'd2;

  logic       out_valid_q;
  logic [1:0] kind_q, kind_d;
  logic [3:0] pin_q, pin_d;
  logic       level_q, level_d;
  logic [7:0] role_q, role_d;
  logic       last_q, last_d;
  logic [1:0] beat_q, beat_d;
  logic       open;
  logic       load;

  assign open  = !out_valid_q || !out_stall_i;
  assign load  = open && !q_stat_i.empty;
  assign pop_o = load && last_d;

  always_comb begin
    kind_d  = head_i.kind;
    pin_d   = head_i.pin;
    level_d = head_i.level;
    role_d  = 8'd0;
    last_d  = 1'b1;
    if (head_i.multi) begin
      case (beat_q)
        BeatFirst: begin
          kind_d  = mpcs_pkg::KindStart;
          pin_d   = 4'd0;
          level_d = 1'b0;
          last_d  = 1'b0;
        end
        BeatCfg: begin
          kind_d  = mpcs_pkg::KindCfgReq;
          pin_d   = 4'd0;
          level_d = 1'b0;
          role_d  = head_i.role;
          last_d  = 1'b0;
        end
        default: begin
          kind_d  = mpcs_pkg::KindSetPin;
          level_d = 1'b0;
        end
      endcase
    end
    beat_d = beat_q;
    if (load) begin
      beat_d = last_d ? BeatFirst : ((beat_q == BeatFirst) ? BeatCfg : BeatPin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= BeatFirst;
    end else begin
      if (open) out_valid_q <= !q_stat_i.empty;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      pin_q   <= pin_d;
      level_q <= level_d;
      role_q  <= role_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign pin_o       = pin_q;
  assign level_o     = level_q;
  assign role_o      = role_q;
  assign last_o      = last_q;

endmodule

[rtl/core/modem_power_config_sequencer_core.sv]
// ----------------------------------------------------------------------------
// modem_power_config_sequencer_core
// Sixteen-phase modem power and configuration sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                                    | direction
//  in      | in_valid_i, in_stall_o, cmd/ack/role_code  | word in
//  out     | out_valid_o, out_stall_i, kind..last       | word out
//  cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i         | write only
//
//  Input words are taken one per cycle while the burst queue has room.
//  A tick drains at the output as one word per cycle while out_stall_i is
//  low: three words for the start burst, one otherwise; the output register
//  sets the result rate. Events produce no words and act in the front only.
//  Reset is asynchronous and empties the queue and output register.
// ----------------------------------------------------------------------------
module modem_power_config_sequencer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [3:0] ack_pin_i,
  input  logic [3:0] ack_level_i,
  input  logic [7:0] role_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [3:0] pin_o,
  output logic       level_o,
  output logic [7:0] role_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_wdata_i
);

  mpcs_pkg::cfg_t    cfg_q;
  mpcs_pkg::q_stat_t q_stat;
  mpcs_pkg::burst_t  push_entry;
  mpcs_pkg::burst_t  head;
  logic              push;
  logic              pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modem_pin  <= 4'd0;
      cfg_q.magnet_pin <= 4'd1;
      cfg_q.enabled    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mpcs_pkg::CfgModemPin:  cfg_q.modem_pin  <= cfg_wdata_i;
        mpcs_pkg::CfgMagnetPin: cfg_q.magnet_pin <= cfg_wdata_i;
        mpcs_pkg::CfgEnable:    cfg_q.enabled    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  mpcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .ack_pin_i   (ack_pin_i),
    .ack_level_i (ack_level_i),
    .role_code_i (role_code_i),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  mpcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head),
    .stat_o  (q_stat)
  );

  mpcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .pin_o       (pin_o),
    .level_o     (level_o),
    .role_o      (role_o),
    .last_o      (last_o)
  );

endmodule

[rtl/core/mpcs_checker.sv]
// ----------------------------------------------------------------------------
// mpcs_port_checks
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "modem_power_config_sequencer_core_defines.svh"

module mpcs_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [3:0] pin_o,
  input logic       level_o,
  input logic [7:0] role_o,
  input logic       last_o
);

  `MPCS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o),
    "stalled output word dropped or changed")

  `MPCS_ASSERT(a_start_not_last, out_valid_o && (kind_o == mpcs_pkg::KindStart),
    !last_o && (role_o == 8'd0), "start mark must open a burst")

  `MPCS_ASSERT_NEXT(a_start_then_cfg,
    out_valid_o && !out_stall_i && (kind_o == mpcs_pkg::KindStart),
    out_valid_o && (kind_o == mpcs_pkg::KindCfgReq) && !last_o,
    "start mark not followed by configuration request")

  `MPCS_ASSERT(a_end_last, out_valid_o && (kind_o == mpcs_pkg::KindEnd),
    last_o && (pin_o == 4'd0) && !level_o && (role_o == 8'd0), "malformed end mark")

endmodule

bind modem_power_config_sequencer_core mpcs_port_checks u_mpcs_port_checks (.*);
